>>> src/llqs_pkg.sv
`default_nettype none

package llqs_pkg;

    // Field widths fixed by the channel definitions
    localparam int FUNC_W       = 2;
    localparam int NODE_FIELD_W = 3;
    localparam int ID_FIELD_W   = 10;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 16;
    localparam int SEED_W       = 64;
    localparam int CFG_INDEX_W  = 1;

    // Remainder unit: one byte of the source per cycle
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = SEED_W / DIGIT_W;

    localparam logic [COUNT_W-1:0] COUNT_CEILING = 16'hFFFF;
    localparam logic [SEED_W-1:0]  LFSR_MASK     = 64'hD800_0000_0000_0000;
    localparam logic [SEED_W-1:0]  LFSR_RESET    = 64'd1;

    localparam int NODES_DEF       = 8;
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int ID_BITS_DEF     = 10;

    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SELECT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ENDED   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_ENABLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_VALUE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOD,
        ST_SCAN,
        ST_PICK,
        ST_READ,
        ST_FINISH
    } state_t;

    // Right-shifting Galois step
    function automatic logic [SEED_W-1:0] lfsr_advance(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_MASK;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/llqs_req_if.sv
`default_nettype none

interface llqs_req_if;
    import llqs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [NODE_FIELD_W-1:0] node_index;
    logic [ID_FIELD_W-1:0]   work_id;

    modport source (output valid, func, node_index, work_id, input ready);
    modport sink   (input valid, func, node_index, work_id, output ready);
endinterface

`default_nettype wire

>>> src/llqs_rsp_if.sv
`default_nettype none

interface llqs_rsp_if;
    import llqs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [ID_FIELD_W-1:0]   chosen_id;
    logic [NODE_FIELD_W-1:0] chosen_node;

    modport source (output valid, status, chosen_id, chosen_node, input ready);
    modport sink   (input valid, status, chosen_id, chosen_node, output ready);
endinterface

`default_nettype wire

>>> src/llqs_mod_unit.sv
`default_nettype none

module llqs_mod_unit #(
    parameter int NODES = llqs_pkg::NODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [llqs_pkg::SEED_W-1:0]   value,
    output logic                          done,
    output logic [$clog2(NODES)-1:0]      rem
);
    import llqs_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int NW1   = NW + 1;
    localparam int CNT_W = $clog2(DIGITS);
    localparam logic [NW1-1:0]   NODES_S  = NW1'(NODES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SEED_W-1:0] shift_reg;
    logic [NW-1:0]     rem_reg;
    logic [NW-1:0]     rem_step;

    // Fold one byte into the remainder, one compare-subtract per bit
    always_comb
    begin
        logic [NW-1:0]      r;
        logic [NW1-1:0]     t;
        logic [DIGIT_W-1:0] digit;
        r     = rem_reg;
        digit = shift_reg[SEED_W-1 -: DIGIT_W];
        for (int b = DIGIT_W - 1; b >= 0; b--)
        begin
            t = {r, digit[b]};
            if (t >= NODES_S)
            begin
                t = t - NODES_S;
            end
            r = t[NW-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg <= value;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << DIGIT_W;
            rem_reg   <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> src/least_loaded_queue_selector.sv
`default_nettype none

// Channel   Direction  Payload                              Beat taken when
// req       in         func, node_index, work_id            req.valid & req.ready
// rsp       out        status, chosen_id, chosen_node       rsp.valid & rsp.ready
// cfg       in         cfg_index, cfg_data (write only)     cfg_we
//
// Enqueue and stream-ended pass through the execute state (ST_EXEC) from accept to result register.
// Select first computes the byte-serial remainder of the tie-break source,
// then scans one node per cycle through the shared scan compare, then reads
// the queue memory and loads the result.
// req.ready is high only between items; a result waiting on rsp does not block
// the next accept, only the next result load. Reset clears the per-node pointers,
// fill levels and stream counters at once; the queue memory is not cleared.

module least_loaded_queue_selector #(
    parameter int NODES       = llqs_pkg::NODES_DEF,
    parameter int QUEUE_DEPTH = llqs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = llqs_pkg::ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [llqs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [llqs_pkg::SEED_W-1:0]      cfg_data,
    llqs_req_if.sink                         req,
    llqs_rsp_if.source                       rsp
);
    import llqs_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int NW1 = NW + 1;
    localparam int CW  = NW + 4;
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int AW  = $clog2(NODES * QUEUE_DEPTH);
    localparam int EW  = (ID_BITS > ID_FIELD_W) ? ID_BITS : ID_FIELD_W;

    localparam logic [CW-1:0]  NODES_C   = CW'(NODES);
    localparam logic [NW1-1:0] NODES_S   = NW1'(NODES);
    localparam logic [NW-1:0]  LAST_NODE = NW'(NODES - 1);
    localparam logic [FW-1:0]  QD_FULL   = FW'(QUEUE_DEPTH);
    localparam logic [PW-1:0]  QD_LAST   = PW'(QUEUE_DEPTH - 1);

    function automatic logic [PW-1:0] wrap_next(input logic [PW-1:0] p);
        return (p == QD_LAST) ? '0 : p + 1'b1;
    endfunction

    state_t state_reg, state_next;

    logic              seed_en_reg, seed_en_next;
    logic [SEED_W-1:0] seed_val_reg, seed_val_next;
    logic [SEED_W-1:0] lfsr_reg, lfsr_next;

    logic [PW-1:0]      head_reg [NODES];
    logic [PW-1:0]      head_next [NODES];
    logic [PW-1:0]      tail_reg [NODES];
    logic [PW-1:0]      tail_next [NODES];
    logic [FW-1:0]      fill_reg [NODES];
    logic [FW-1:0]      fill_next [NODES];
    logic [COUNT_W-1:0] act_reg [NODES];
    logic [COUNT_W-1:0] act_next [NODES];

    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [CW-1:0]      node_reg, node_next;
    logic [ID_BITS-1:0] id_reg, id_next;

    logic [NW-1:0]      start_reg, start_next;
    logic [NW-1:0]      scan_reg, scan_next;
    logic [NW-1:0]      best_reg, best_next;
    logic [COUNT_W-1:0] best_cnt_reg, best_cnt_next;
    logic               found_reg, found_next;

    status_t                 res_status_reg, res_status_next;
    logic [ID_FIELD_W-1:0]   res_id_reg, res_id_next;
    logic [NODE_FIELD_W-1:0] res_node_reg, res_node_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [ID_FIELD_W-1:0]   out_id_reg, out_id_next;
    logic [NODE_FIELD_W-1:0] out_node_reg, out_node_next;

    logic [ID_BITS-1:0] mem [NODES * QUEUE_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;

    logic              mod_load, mod_done;
    logic [NW-1:0]     mod_rem;
    logic [SEED_W-1:0] mod_value;

    logic [NW-1:0]  node_idx;
    logic           node_ok;
    logic [NW1-1:0] scan_sum;
    logic [NW-1:0]  scan_node;
    logic [EW-1:0]  id_in_ext;
    logic [EW-1:0]  rd_ext;
    logic [CW-1:0]  best_ext;
    logic           out_free;

    llqs_mod_unit #(
        .NODES (NODES)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (mod_load),
        .value (mod_value),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign mod_value = seed_en_reg ? seed_val_reg : lfsr_reg;
    assign node_idx  = node_reg[NW-1:0];
    assign node_ok   = node_reg < NODES_C;
    assign id_in_ext = EW'(req.work_id);
    assign rd_ext    = EW'(rd_data_reg);
    assign best_ext  = CW'(best_reg);
    assign out_free  = !out_valid_reg || rsp.ready;

    // Rotated scan position
    always_comb
    begin
        scan_sum = NW1'(start_reg) + NW1'(scan_reg);
        if (scan_sum >= NODES_S)
        begin
            scan_sum = scan_sum - NODES_S;
        end
        scan_node = scan_sum[NW-1:0];
    end

    assign mem_waddr = AW'(node_idx * QUEUE_DEPTH) + AW'(tail_reg[node_idx]);
    assign mem_raddr = AW'(best_reg * QUEUE_DEPTH) + AW'(head_reg[best_reg]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.func == FUNC_SELECT) ? ST_MOD : ST_EXEC;
                end
            end
            ST_EXEC:   state_next = ST_FINISH;
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == LAST_NODE)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:   state_next = found_reg ? ST_READ : ST_FINISH;
            ST_READ:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        seed_en_next    = seed_en_reg;
        seed_val_next   = seed_val_reg;
        lfsr_next       = lfsr_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        act_next        = act_reg;
        func_next       = func_reg;
        node_next       = node_reg;
        id_next         = id_reg;
        start_next      = start_reg;
        scan_next       = scan_reg;
        best_next       = best_reg;
        best_cnt_next   = best_cnt_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_node_next   = res_node_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_node_next   = out_node_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mod_load        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEED_ENABLE: seed_en_next = cfg_data[0];
                CFG_SEED_VALUE:
                begin
                    seed_val_next = cfg_data;
                    lfsr_next     = (cfg_data == '0) ? LFSR_RESET : cfg_data;
                end
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next = req.func;
                    node_next = CW'(req.node_index);
                    id_next   = id_in_ext[ID_BITS-1:0];
                    if (req.func == FUNC_SELECT)
                    begin
                        mod_load = 1'b1;
                        if (!seed_en_reg)
                        begin
                            lfsr_next = lfsr_advance(lfsr_reg);
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                res_status_next = STATUS_OK;
                res_id_next     = '0;
                res_node_next   = '0;
                case (func_reg)
                    FUNC_ENQUEUE:
                    begin
                        if (!node_ok)
                        begin
                            res_status_next = STATUS_RANGE;
                        end
                        else if (fill_reg[node_idx] == QD_FULL)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            tail_next[node_idx] = wrap_next(tail_reg[node_idx]);
                            fill_next[node_idx] = fill_reg[node_idx] + 1'b1;
                        end
                    end
                    FUNC_ENDED:
                    begin
                        if (!node_ok)
                        begin
                            res_status_next = STATUS_RANGE;
                        end
                        else if (act_reg[node_idx] != '0)
                        begin
                            act_next[node_idx] = act_reg[node_idx] - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MOD:
            begin
                start_next    = mod_rem;
                scan_next     = '0;
                best_cnt_next = COUNT_CEILING;
                found_next    = 1'b0;
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (fill_reg[scan_node] != '0 && act_reg[scan_node] < best_cnt_reg)
                begin
                    best_next     = scan_node;
                    best_cnt_next = act_reg[scan_node];
                    found_next    = 1'b1;
                end
            end
            ST_PICK:
            begin
                res_id_next   = '0;
                res_node_next = '0;
                if (!found_reg)
                begin
                    res_status_next = STATUS_EMPTY;
                end
                else
                begin
                    res_status_next     = STATUS_OK;
                    res_node_next       = best_ext[NODE_FIELD_W-1:0];
                    mem_re              = 1'b1;
                    head_next[best_reg] = wrap_next(head_reg[best_reg]);
                    fill_next[best_reg] = fill_reg[best_reg] - 1'b1;
                    if (act_reg[best_reg] < COUNT_CEILING - 1'b1)
                    begin
                        act_next[best_reg] = act_reg[best_reg] + 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                res_id_next = rd_ext[ID_FIELD_W-1:0];
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_node_next   = res_node_reg;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        req.ready       = (state_reg == ST_IDLE);
        rsp.valid       = out_valid_reg;
        rsp.status      = out_status_reg;
        rsp.chosen_id   = out_id_reg;
        rsp.chosen_node = out_node_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_en_reg   <= 1'b0;
            seed_val_reg  <= '0;
            lfsr_reg      <= LFSR_RESET;
            head_reg      <= '{default: '0};
            tail_reg      <= '{default: '0};
            fill_reg      <= '{default: '0};
            act_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_en_reg   <= seed_en_next;
            seed_val_reg  <= seed_val_next;
            lfsr_reg      <= lfsr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        node_reg       <= node_next;
        id_reg         <= id_next;
        start_reg      <= start_next;
        scan_reg       <= scan_next;
        best_reg       <= best_next;
        best_cnt_reg   <= best_cnt_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_node_reg   <= res_node_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_node_reg   <= out_node_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= id_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> tb/least_loaded_queue_selector_test.sv
module least_loaded_queue_selector_test;
    import llqs_pkg::*;

    localparam int NODES       = NODES_DEF;
    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int FILL_NODE   = 5;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        status_t                 status;
        logic [ID_FIELD_W-1:0]   id;
        logic [NODE_FIELD_W-1:0] node;
    } result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [NODE_FIELD_W-1:0] node;
        logic [ID_FIELD_W-1:0]   id;
        bit                      typed;
        result_t                 res;
    } step_row_t;

    localparam result_t RES_OK    = '{STATUS_OK, 10'd0, 3'd0};
    localparam result_t RES_EMPTY = '{STATUS_EMPTY, 10'd0, 3'd0};

    localparam int N_ROWS = 24;
    localparam step_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b1, RES_EMPTY},
        '{FUNC_ENDED,   3'd0, 10'd0,     1'b1, RES_OK},
        '{FUNC_UNUSED,  3'd7, 10'd1023,  1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd0, 10'd0,     1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd7, 10'd1023,  1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd3, 10'h155,   1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd4, 10'h2AA,   1'b1, RES_OK},
        '{FUNC_SELECT,  3'd7, 10'd1023,  1'b0, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b1, RES_EMPTY},
        '{FUNC_ENDED,   3'd7, 10'd0,     1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd7, 10'd1,     1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd7, 10'd2,     1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd2, 10'd3,     1'b1, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_ENDED,   3'd1, 10'd1023,  1'b1, RES_OK},
        '{FUNC_ENDED,   3'd7, 10'd0,     1'b1, RES_OK},
        '{FUNC_ENQUEUE, 3'd0, 10'd1023,  1'b1, RES_OK},
        '{FUNC_SELECT,  3'd0, 10'd0,     1'b0, RES_OK},
        '{FUNC_UNUSED,  3'd0, 10'd0,     1'b1, RES_OK}
    };

    logic clk;
    logic rst_n;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [SEED_W-1:0]       cfg_data;

    llqs_req_if req_bus ();
    llqs_rsp_if rsp_bus ();

    least_loaded_queue_selector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Predictor state
    logic [ID_FIELD_W-1:0] id_store [NODES][QUEUE_DEPTH];
    logic [7:0]            q_head [NODES];
    logic [7:0]            q_tail [NODES];
    logic [8:0]            q_fill [NODES];
    logic [COUNT_W-1:0]    streams [NODES];
    logic [SEED_W-1:0]     tie_shift;
    bit                    seed_on;
    logic [SEED_W-1:0]     seed_reg;
    bit                    last_pick_ok;
    int                    last_pick_node;

    result_t pending_results [$];
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      results_seen = 0;
    bit      hold_rsp     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit quiet_stretch(input int n);
        return ((n / 128) % 4) == 1;
    endfunction

    function automatic void selector_reset();
        for (int n = 0; n < NODES; n++)
        begin
            q_head[n]  = '0;
            q_tail[n]  = '0;
            q_fill[n]  = '0;
            streams[n] = '0;
        end
        tie_shift      = LFSR_RESET;
        seed_on        = 1'b0;
        seed_reg       = '0;
        last_pick_ok   = 1'b0;
        last_pick_node = 0;
    endfunction

    function automatic int ids_waiting();
        int total;
        total = 0;
        for (int n = 0; n < NODES; n++)
        begin
            total += int'(q_fill[n]);
        end
        return total;
    endfunction

    function automatic result_t predict_pick(input logic [FUNC_W-1:0] f,
                                             input logic [NODE_FIELD_W-1:0] n,
                                             input logic [ID_FIELD_W-1:0] w);
        result_t r;
        int      start;
        int      cand;
        int      best;
        int      best_count;
        bit      found;
        r          = RES_OK;
        best       = 0;
        best_count = int'(COUNT_CEILING);
        found      = 1'b0;
        case (f)
            FUNC_ENQUEUE:
            begin
                if (int'(n) >= NODES)
                begin
                    r.status = STATUS_RANGE;
                end
                else if (q_fill[n] >= QUEUE_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    id_store[n][q_tail[n]] = w;
                    // 8-bit pointer wraps at the queue depth
                    q_tail[n] = q_tail[n] + 8'd1;
                    q_fill[n] = q_fill[n] + 9'd1;
                end
            end
            FUNC_SELECT:
            begin
                if (seed_on)
                begin
                    start = int'(seed_reg % NODES);
                end
                else
                begin
                    start = int'(tie_shift % NODES);
                    tie_shift = (tie_shift >> 1) ^ (tie_shift[0] ? LFSR_MASK : '0);
                end
                for (int i = 0; i < NODES; i++)
                begin
                    cand = (start + i) % NODES;
                    if (q_fill[cand] != 0 && int'(streams[cand]) < best_count)
                    begin
                        best_count = int'(streams[cand]);
                        best       = cand;
                        found      = 1'b1;
                    end
                end
                last_pick_ok = found;
                if (!found)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    r.id         = id_store[best][q_head[best]];
                    r.node       = best[NODE_FIELD_W-1:0];
                    q_head[best] = q_head[best] + 8'd1;
                    q_fill[best] = q_fill[best] - 9'd1;
                    if (streams[best] < COUNT_CEILING - 16'd1)
                    begin
                        streams[best] = streams[best] + 16'd1;
                    end
                    last_pick_node = best;
                end
            end
            FUNC_ENDED:
            begin
                if (int'(n) >= NODES)
                begin
                    r.status = STATUS_RANGE;
                end
                else if (streams[n] != 0)
                begin
                    streams[n] = streams[n] - 16'd1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Offer one beat, hold it until taken, then queue its expected result.
    task automatic offer(input logic [FUNC_W-1:0] f, input logic [NODE_FIELD_W-1:0] n,
                         input logic [ID_FIELD_W-1:0] w, input bit typed, input result_t res);
        int      gap;
        result_t predicted;
        gap = quiet_stretch(items_sent) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.func       <= f;
        req_bus.node_index <= n;
        req_bus.work_id    <= w;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        items_sent++;
        predicted = predict_pick(f, n, w);
        pending_results.push_back(typed ? res : predicted);
    endtask

    task automatic offer_random();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            offer(FUNC_ENQUEUE, NODE_FIELD_W'($urandom_range(0, 7)),
                  ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
        end
        else if (pick < 75)
        begin
            offer(FUNC_SELECT, NODE_FIELD_W'($urandom_range(0, 7)),
                  ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
        end
        else if (pick < 95)
        begin
            offer(FUNC_ENDED, NODE_FIELD_W'($urandom_range(0, 7)),
                  ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
        end
        else
        begin
            offer(FUNC_UNUSED, NODE_FIELD_W'($urandom_range(0, 7)),
                  ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
        end
    endtask

    // Drop valid, wait for every result, then let the block go quiet.
    task automatic settle();
        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic load_settings(input bit enable, input logic [SEED_W-1:0] seed);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEED_ENABLE;
        cfg_data  <= {{(SEED_W-1){1'b0}}, enable};
        @(posedge clk);
        cfg_index <= CFG_SEED_VALUE;
        cfg_data  <= seed;
        @(posedge clk);
        cfg_we <= 1'b0;
        seed_on   = enable;
        seed_reg  = seed;
        tie_shift = (seed == '0) ? LFSR_RESET : seed;
    endtask

    // Push one node to full and past it, then pop everything so pointers wrap.
    task automatic fill_and_drain();
        while (q_fill[FILL_NODE] < QUEUE_DEPTH)
        begin
            offer(FUNC_ENQUEUE, NODE_FIELD_W'(FILL_NODE),
                  ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
        end
        repeat (3) offer(FUNC_ENQUEUE, NODE_FIELD_W'(FILL_NODE),
                         ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
        while (ids_waiting() != 0)
        begin
            offer(FUNC_SELECT, NODE_FIELD_W'($urandom_range(0, 7)),
                  ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
            if (last_pick_ok && $urandom_range(0, 1) == 1)
            begin
                offer(FUNC_ENDED, NODE_FIELD_W'(last_pick_node),
                      ID_FIELD_W'($urandom_range(0, 1023)), 1'b0, RES_OK);
            end
        end
    endtask

    initial
    begin : stimulus
        bit              enable;
        logic [SEED_W-1:0] seed;
        req_bus.valid      <= 1'b0;
        req_bus.func       <= '0;
        req_bus.node_index <= '0;
        req_bus.work_id    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        selector_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            offer(DIRECTED_ROWS[r].func, DIRECTED_ROWS[r].node, DIRECTED_ROWS[r].id,
                  DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: begin enable = 1'b0; seed = {$urandom, $urandom}; end
                1: begin enable = 1'b1; seed = '1; end
                2: begin enable = 1'b1; seed = '0; end
                3: begin enable = 1'b0; seed = '0; end
                4: begin enable = 1'b1; seed = {$urandom, $urandom}; end
                default: begin enable = 1'b0; seed = '1; end
            endcase
            load_settings(enable, seed);
            repeat (PHASE_ITEMS) offer_random();
            if (ph == 2)
            begin
                fill_and_drain();
            end
        end

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Long hold-off on the result side while the sender keeps offering.
    initial
    begin : result_hold
        wait (results_seen >= HOLD_AFTER);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin : result_sink
        int      gap;
        result_t want;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = quiet_stretch(results_seen) ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            while (hold_rsp)
            begin
                rsp_bus.ready <= 1'b0;
                @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_seen, rsp_bus.status, want.status));
                end
                if (rsp_bus.chosen_id !== want.id)
                begin
                    report_mismatch($sformatf("result %0d chosen_id %0d, expected %0d",
                                              results_seen, rsp_bus.chosen_id, want.id));
                end
                if (rsp_bus.chosen_node !== want.node)
                begin
                    report_mismatch($sformatf("result %0d chosen_node %0d, expected %0d",
                                              results_seen, rsp_bus.chosen_node, want.node));
                end
            end
        end
    end

endmodule

>>> filelist.f
src/llqs_pkg.sv
src/llqs_req_if.sv
src/llqs_rsp_if.sv
src/llqs_mod_unit.sv
src/least_loaded_queue_selector.sv
tb/least_loaded_queue_selector_test.sv
